/* hdl/tctt_pkg.sv */
// Shared constants, status codes and register indexes for the thermistor converter.
package tctt_pkg;

	localparam int LOG_IN_W   = 30;
	localparam int LOG_FRAC_W = 20;
	localparam int LOG_K_W    = 5;
	localparam int LOG_OUT_W  = 21;
	localparam int LOG_LAT    = LOG_FRAC_W + 3;

	localparam int VQ_W = 30;
	localparam int VD_W = 46;
	localparam int TQ_W = 18;
	localparam int TD_W = 40;
	localparam int TR_W = 58;

	localparam logic [29:0] LN2_Q30      = 30'd744261118;
	localparam logic [22:0] SCALE_Q16    = 23'd6553600;
	localparam logic [21:0] T0_SCALE     = 22'd2981500;
	localparam logic [15:0] T0_CENTI_K   = 16'd29815;
	localparam logic [19:0] ZERO_C_CENTI = 20'd27315;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_RES  = 2'd2;
	localparam logic [1:0] ST_SAT  = 2'd3;

	localparam logic [2:0] REG_NOMINAL   = 3'd0;
	localparam logic [2:0] REG_BETA      = 3'd1;
	localparam logic [2:0] REG_LOAD      = 3'd2;
	localparam logic [2:0] REG_FULLSCALE = 3'd3;
	localparam logic [2:0] REG_DRIVE     = 3'd4;
	localparam logic [2:0] REG_OFFSET    = 3'd5;
	localparam logic [2:0] REG_PULLDOWN  = 3'd6;
	localparam logic [2:0] REG_COUNTMAX  = 3'd7;

endpackage

/* hdl/thermistor_counts_to_temperature.sv */
// Throughput: one word per cycle; the 30-step voltage divider, four 23-stage
// log units and the 18-step temperature divider are fully pipelined.
// A held result word freezes the whole pipe; sample_stall rises only then.
// Reset (arst_n low) clears all valid bits and loads register defaults.
module thermistor_counts_to_temperature
	import tctt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [15:0] adc_count,
	output logic        result_valid,
	input  logic        result_stall,
	output logic signed [15:0] temperature_centi,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	logic [23:0] rnom_q;
	logic [14:0] beta_q;
	logic [23:0] rl_q;
	logic [13:0] fs_q;
	logic [13:0] dv_q;
	logic [14:0] offs_q;
	logic        pd_q;
	logic [15:0] cmax_q;

	logic        adv;
	logic [15:0] cmax_e;
	logic [14:0] beta_e;
	logic [23:0] rnom_e;

	logic        vld_s1;
	logic [29:0] prod_s1;
	logic        cz_s1;

	logic [VQ_W:0]     vv_s;
	logic [VD_W-1:0]   vrem_s [0:VQ_W];
	logic [VQ_W-1:0]   vq_s [0:VQ_W];
	logic              vz_s [0:VQ_W];
	logic              vbig_s [0:VQ_W];
	logic [VD_W-1:0]   vp_c;

	logic        vld_s3;
	logic [29:0] v_s3;
	logic [29:0] dmv_s3;
	logic [1:0]  st_s3;
	logic [29:0] d_c;
	logic [1:0]  st_c;

	logic [LOG_OUT_W-1:0] ln_rl;
	logic [LOG_OUT_W-1:0] ln_v;
	logic [LOG_OUT_W-1:0] ln_dmv;
	logic [LOG_OUT_W-1:0] ln_rn;
	logic [LOG_LAT-1:0]   lv_s;
	logic [1:0]           lst_s [0:LOG_LAT];

	logic               vld_s4;
	logic signed [23:0] l_s4;
	logic [1:0]         st_s4;
	logic signed [23:0] l_c;

	logic               vld_s5;
	logic [37:0]        dena_s5;
	logic signed [40:0] denb_s5;
	logic [36:0]        numa_s5;
	logic [1:0]         st_s5;

	logic               vld_s6;
	logic signed [40:0] den_s6;
	logic [52:0]        num_s6;
	logic [1:0]         st_s6;

	logic [TD_W-1:0] dpos_c;
	logic [TR_W-1:0] n_c;

	logic [TQ_W:0]   tv_s;
	logic [TR_W-1:0] trem_s [0:TQ_W];
	logic [TD_W-1:0] tden_s [0:TQ_W];
	logic [TQ_W-1:0] tq_s [0:TQ_W];
	logic            trun_s [0:TQ_W];
	logic            tbig_s [0:TQ_W];
	logic [1:0]      tst_s [0:TQ_W];

	logic signed [19:0] t_c;
	logic               vout_q;
	logic signed [15:0] tout_q;
	logic [1:0]         sout_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnom_q <= 24'd100000;
			beta_q <= 15'd3950;
			rl_q   <= 24'd10000;
			fs_q   <= 14'd1000;
			dv_q   <= 14'd3300;
			offs_q <= '0;
			pd_q   <= 1'b0;
			cmax_q <= 16'd1023;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_NOMINAL:   rnom_q <= cfg_data;
				REG_BETA:      beta_q <= cfg_data[14:0];
				REG_LOAD:      rl_q   <= cfg_data;
				REG_FULLSCALE: fs_q   <= cfg_data[13:0];
				REG_DRIVE:     dv_q   <= cfg_data[13:0];
				REG_OFFSET:    offs_q <= cfg_data[14:0];
				REG_PULLDOWN:  pd_q   <= cfg_data[0];
				REG_COUNTMAX:  cmax_q <= cfg_data[15:0];
				default:       pd_q   <= pd_q;
			endcase
		end
	end

	assign cmax_e = (cmax_q == '0) ? 16'd1 : cmax_q;
	assign beta_e = (beta_q == '0) ? 15'd1 : beta_q;
	assign rnom_e = (rnom_q == '0) ? 24'd1 : rnom_q;

	assign adv          = !vout_q || !result_stall;
	assign sample_stall = !adv;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vv_s   <= '0;
			vld_s3 <= 1'b0;
			lv_s   <= '0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			tv_s   <= '0;
			vout_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= sample_valid;
			vv_s   <= {vv_s[VQ_W-1:0], vld_s1};
			vld_s3 <= vv_s[VQ_W];
			lv_s   <= {lv_s[LOG_LAT-2:0], vld_s3};
			vld_s4 <= lv_s[LOG_LAT-1];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			tv_s   <= {tv_s[TQ_W-1:0], vld_s6};
			vout_q <= tv_s[TQ_W];
		end
	end

	// sense voltage: fs * count * 65536 / cmax
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= 30'(fs_q) * 30'(adc_count);
			cz_s1   <= (adc_count == '0);
		end
	end

	assign vp_c = {prod_s1, 16'd0};

	always_ff @(posedge clk) begin
		if (adv) begin
			vrem_s[0] <= vp_c;
			vq_s[0]   <= '0;
			vz_s[0]   <= cz_s1;
			vbig_s[0] <= (vp_c >= {cmax_e, 30'd0});
		end
	end

	for (genvar g = 0; g < VQ_W; g++) begin : g_vdiv
		logic [VD_W-1:0] sh;
		assign sh = VD_W'(cmax_e) << (VQ_W-1-g);
		always_ff @(posedge clk) begin
			if (adv) begin
				vz_s[g+1]   <= vz_s[g];
				vbig_s[g+1] <= vbig_s[g];
				if (vrem_s[g] >= sh) begin
					vrem_s[g+1] <= vrem_s[g] - sh;
					vq_s[g+1]   <= vq_s[g] | (VQ_W'(1) << (VQ_W-1-g));
				end else begin
					vrem_s[g+1] <= vrem_s[g];
					vq_s[g+1]   <= vq_s[g];
				end
			end
		end
	end

	assign d_c = {dv_q, 16'd0};

	always_comb begin
		if (vz_s[VQ_W] || (!vbig_s[VQ_W] && vq_s[VQ_W] == '0)) begin
			st_c = ST_ZERO;
		end else if (rl_q == '0 || vbig_s[VQ_W] || d_c <= vq_s[VQ_W]) begin
			st_c = ST_RES;
		end else begin
			st_c = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s3   <= vq_s[VQ_W];
			dmv_s3 <= d_c - vq_s[VQ_W];
			st_s3  <= st_c;
		end
	end

	tctt_log u_log_rl  (.clk(clk), .en(adv), .x(LOG_IN_W'(rl_q)),   .y(ln_rl));
	tctt_log u_log_v   (.clk(clk), .en(adv), .x(v_s3),              .y(ln_v));
	tctt_log u_log_dmv (.clk(clk), .en(adv), .x(dmv_s3),            .y(ln_dmv));
	tctt_log u_log_rn  (.clk(clk), .en(adv), .x(LOG_IN_W'(rnom_e)), .y(ln_rn));

	always_comb begin
		lst_s[0] = st_s3;
	end

	for (genvar g = 0; g < LOG_LAT; g++) begin : g_lside
		always_ff @(posedge clk) begin
			if (adv) begin
				lst_s[g+1] <= lst_s[g];
			end
		end
	end

	always_comb begin
		if (pd_q) begin
			l_c = $signed(24'(ln_rl)) + $signed(24'(ln_v)) - $signed(24'(ln_dmv))
				- $signed(24'(ln_rn));
		end else begin
			l_c = $signed(24'(ln_rl)) + $signed(24'(ln_dmv)) - $signed(24'(ln_v))
				- $signed(24'(ln_rn));
		end
	end

	// beta equation terms
	always_ff @(posedge clk) begin
		if (adv) begin
			l_s4    <= l_c;
			st_s4   <= lst_s[LOG_LAT];
			dena_s5 <= 38'(beta_e) * 38'(SCALE_Q16);
			denb_s5 <= 41'(l_s4) * $signed({25'd0, T0_CENTI_K});
			numa_s5 <= 37'(beta_e) * 37'(T0_SCALE);
			st_s5   <= st_s4;
			den_s6  <= $signed({3'd0, dena_s5}) + denb_s5;
			num_s6  <= {numa_s5, 16'd0};
			st_s6   <= st_s5;
		end
	end

	assign dpos_c = den_s6[TD_W-1:0];
	assign n_c    = TR_W'(num_s6) + TR_W'(dpos_c >> 1);

	always_ff @(posedge clk) begin
		if (adv) begin
			trem_s[0] <= n_c;
			tden_s[0] <= dpos_c;
			tq_s[0]   <= '0;
			trun_s[0] <= den_s6[40] || (den_s6 == '0);
			tbig_s[0] <= (n_c >= {dpos_c, 18'd0});
			tst_s[0]  <= st_s6;
		end
	end

	for (genvar g = 0; g < TQ_W; g++) begin : g_tdiv
		logic [TR_W-1:0] sh;
		assign sh = TR_W'(tden_s[g]) << (TQ_W-1-g);
		always_ff @(posedge clk) begin
			if (adv) begin
				tden_s[g+1] <= tden_s[g];
				trun_s[g+1] <= trun_s[g];
				tbig_s[g+1] <= tbig_s[g];
				tst_s[g+1]  <= tst_s[g];
				if (trem_s[g] >= sh) begin
					trem_s[g+1] <= trem_s[g] - sh;
					tq_s[g+1]   <= tq_s[g] | (TQ_W'(1) << (TQ_W-1-g));
				end else begin
					trem_s[g+1] <= trem_s[g];
					tq_s[g+1]   <= tq_s[g];
				end
			end
		end
	end

	assign t_c = $signed(20'(tq_s[TQ_W])) - $signed(ZERO_C_CENTI)
		+ $signed({{5{offs_q[14]}}, offs_q});

	always_ff @(posedge clk) begin
		if (adv) begin
			if (tst_s[TQ_W] != ST_OK) begin
				tout_q <= '0;
				sout_q <= tst_s[TQ_W];
			end else if (trun_s[TQ_W] || tbig_s[TQ_W] || t_c > 20'sd32767) begin
				tout_q <= 16'sh7FFF;
				sout_q <= ST_SAT;
			end else if (t_c < -20'sd32768) begin
				tout_q <= 16'sh8000;
				sout_q <= ST_SAT;
			end else begin
				tout_q <= t_c[15:0];
				sout_q <= ST_OK;
			end
		end
	end

	assign result_valid      = vout_q;
	assign temperature_centi = tout_q;
	assign status            = sout_q;

`ifndef SYNTHESIS
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_ZERO || status == ST_RES) |-> temperature_centi == 16'sd0)
		else $error("fault word carries nonzero temperature");
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_SAT
		|-> (temperature_centi == 16'sh7FFF || temperature_centi == 16'sh8000))
		else $error("saturated word not at a rail");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (result_valid && result_stall))
		else $error("input stalled without a held result");
`endif

endmodule

/* hdl/tctt_log.sv */
// Pipelined natural log in Q16 by normalize and square-and-compare steps.
module tctt_log
	import tctt_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic [LOG_IN_W-1:0]  x,
	output logic [LOG_OUT_W-1:0] y
);

	logic [LOG_K_W-1:0]    k_c;
	logic [31:0]           m_s [0:LOG_FRAC_W];
	logic [LOG_K_W-1:0]    k_s [0:LOG_FRAC_W];
	logic [LOG_FRAC_W-1:0] f_s [0:LOG_FRAC_W];
	logic [54:0]           prod_s;
	logic [54:0]           rnd;
	logic [LOG_OUT_W-1:0]  y_q;

	always_comb begin
		k_c = '0;
		for (int i = 0; i < LOG_IN_W; i++) begin
			if (x[i]) begin
				k_c = LOG_K_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0] <= 32'(x) << (LOG_K_W'(31) - k_c);
			k_s[0] <= k_c;
			f_s[0] <= '0;
		end
	end

	for (genvar g = 0; g < LOG_FRAC_W; g++) begin : g_step
		logic [63:0] sq;
		logic [32:0] t;
		assign sq = 64'(m_s[g]) * 64'(m_s[g]);
		assign t  = sq[63:31];
		always_ff @(posedge clk) begin
			if (en) begin
				k_s[g+1] <= k_s[g];
				if (t[32]) begin
					m_s[g+1] <= t[32:1];
					f_s[g+1] <= f_s[g] | (LOG_FRAC_W'(1) << (LOG_FRAC_W-1-g));
				end else begin
					m_s[g+1] <= t[31:0];
					f_s[g+1] <= f_s[g];
				end
			end
		end
	end

	assign rnd = prod_s + (55'(1) << 33);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s <= 55'({k_s[LOG_FRAC_W], f_s[LOG_FRAC_W]}) * 55'(LN2_Q30);
			y_q    <= rnd[54:34];
		end
	end

	assign y = y_q;

endmodule

/* sim/tb_thermistor_counts_to_temperature.sv */
// Self-checking testbench for the thermistor count to temperature converter.
`timescale 1ns / 1ps

module tb_thermistor_counts_to_temperature
	import tctt_pkg::*;
();

	typedef struct {
		logic signed [15:0] temp;
		logic [1:0]         st;
	} reading_t;

	typedef struct {
		logic [15:0] count;
		bit          known;
		reading_t    want;
	} sample_row_t;

	localparam int REG_WIDTH [8] = '{24, 15, 24, 14, 14, 15, 1, 16};
	localparam int LIMIT_CYCLES = 2000000;
	localparam int RAND_PER_PHASE = 165;
	localparam int NUM_PHASES = 10;

	logic        clk;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_stall;
	logic [15:0] adc_count;
	logic        result_valid;
	logic        result_stall;
	logic signed [15:0] temperature_centi;
	logic [1:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	logic [23:0] cal_regs [8];
	reading_t    pending_readings [$];
	int          mismatches;
	int          readings_checked;
	int          samples_sent;
	int          cycle_count;
	bit          quiet;
	bit          hold_long;
	int          status_seen [4];

	thermistor_counts_to_temperature dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.adc_count(adc_count),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.temperature_centi(temperature_centi),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint ln_q16(logic [63:0] x);
		int k;
		logic [63:0] m;
		logic [63:0] l2;
		k = 63;
		while (x[k] == 1'b0 && k > 0)
			k--;
		m = (k >= 31) ? (x >> (k - 31)) : (x << (31 - k));
		l2 = 64'(k) << 20;
		for (int i = 19; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				l2[i] = 1'b1;
			end
		end
		return longint'((l2 * 64'(LN2_Q30) + (64'd1 << 33)) >> 34);
	endfunction

	function automatic reading_t convert_count(logic [15:0] count);
		reading_t r;
		logic [63:0] rnom, rl, cmax, v, d;
		longint beta, offs, lg, num, den, t;
		rnom = (cal_regs[REG_NOMINAL] != 0) ? 64'(cal_regs[REG_NOMINAL]) : 64'd1;
		beta = (cal_regs[REG_BETA] != 0) ? longint'(cal_regs[REG_BETA]) : 1;
		rl = 64'(cal_regs[REG_LOAD]);
		cmax = (cal_regs[REG_COUNTMAX] != 0) ? 64'(cal_regs[REG_COUNTMAX]) : 64'd1;
		offs = longint'($signed(cal_regs[REG_OFFSET][14:0]));
		v = (64'(cal_regs[REG_FULLSCALE]) * 64'(count) * 64'd65536) / cmax;
		d = 64'(cal_regs[REG_DRIVE]) << 16;
		r.temp = '0;
		r.st = ST_OK;
		if (count == 0 || v == 0) begin
			r.st = ST_ZERO;
			return r;
		end
		if (rl == 0 || d <= v) begin
			r.st = ST_RES;
			return r;
		end
		if (cal_regs[REG_PULLDOWN][0])
			lg = ln_q16(rl) + ln_q16(v) - ln_q16(d - v) - ln_q16(rnom);
		else
			lg = ln_q16(rl) + ln_q16(d - v) - ln_q16(v) - ln_q16(rnom);
		den = longint'(SCALE_Q16) * beta + longint'(T0_CENTI_K) * lg;
		if (den <= 0) begin
			r.temp = 16'sh7FFF;
			r.st = ST_SAT;
			return r;
		end
		num = longint'(T0_CENTI_K) * beta * longint'(SCALE_Q16);
		t = (num + den / 2) / den - longint'(ZERO_C_CENTI) + offs;
		if (t > 32767) begin
			t = 32767;
			r.st = ST_SAT;
		end else if (t < -32768) begin
			t = -32768;
			r.st = ST_SAT;
		end
		r.temp = 16'(t);
		return r;
	endfunction

	task automatic write_cal(logic [2:0] idx, logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cal_regs[idx] = value & ((24'd1 << REG_WIDTH[idx]) - 24'd1);
	endtask

	task automatic write_all(logic [23:0] vals [8]);
		for (int i = 0; i < 8; i++)
			write_cal(3'(i), vals[i]);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(logic [15:0] count, bit known, reading_t want);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		adc_count <= count;
		do @(posedge clk); while (sample_stall);
		pending_readings.push_back(known ? want : convert_count(count));
		samples_sent++;
	endtask

	task automatic drain;
		sample_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_count;
		int span;
		span = cal_regs[REG_COUNTMAX];
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'($urandom_range(0, 3));
			2: return 16'(span);
			default: return 16'($urandom_range(0, span));
		endcase
	endfunction

	always @(posedge clk) begin
		reading_t want;
		if (result_valid && !result_stall) begin
			readings_checked++;
			status_seen[status]++;
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: temp %0d status %0d",
						temperature_centi, status);
			end else begin
				want = pending_readings.pop_front();
				if (want.temp !== temperature_centi || want.st !== status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected temp %0d status %0d, got temp %0d status %0d",
							want.temp, want.st, temperature_centi, status);
				end
			end
		end
	end

	initial begin
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				result_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_long = 1'b0;
			end else if (quiet) begin
				result_stall <= 1'b0;
				@(posedge clk);
			end else begin
				result_stall <= ($urandom_range(0, 2) == 0);
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		sample_row_t rows [$];
		logic [23:0] vals [8];
		reading_t none;
		none.temp = '0;
		none.st = ST_OK;
		mismatches = 0;
		readings_checked = 0;
		samples_sent = 0;
		cycle_count = 0;
		quiet = 1'b0;
		hold_long = 1'b0;
		status_seen = '{0, 0, 0, 0};
		arst_n = 1'b0;
		sample_valid = 1'b0;
		adc_count = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cal_regs = '{24'd100000, 24'd3950, 24'd10000, 24'd1000, 24'd3300, 24'd0, 24'd0,
			24'd1023};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{16'd0,     1'b1, '{16'sd0, ST_ZERO}},
			'{16'd65535, 1'b1, '{16'sd0, ST_RES}},
			'{16'd4000,  1'b1, '{16'sd0, ST_RES}},
			'{16'd3379,  1'b1, '{16'sd0, ST_RES}},
			'{16'd1,     1'b0, none},
			'{16'd2,     1'b0, none},
			'{16'd1023,  1'b0, none},
			'{16'd1022,  1'b0, none},
			'{16'd1024,  1'b0, none},
			'{16'd3374,  1'b0, none},
			'{16'd511,   1'b0, none},
			'{16'd100,   1'b0, none},
			'{16'd310,   1'b0, none},
			'{16'h5555,  1'b0, none},
			'{16'h2AAA,  1'b0, none},
			'{16'h0FFF,  1'b0, none}
		};
		foreach (rows[i])
			send_sample(rows[i].count, rows[i].known, rows[i].want);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			case (p)
				0: vals = '{24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 24'h7FFF & -24'sd10000, 24'd0,
					24'd1};
				1: vals = '{24'd10000000, 24'd20000, 24'd10000000, 24'd10000, 24'd10000,
					24'd10000, 24'd1, 24'd65535};
				2: vals = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
				3: vals = '{24'd10000000, 24'd1, 24'd1, 24'd3300, 24'd3300, 24'd0, 24'd0,
					24'd1023};
				4: for (int i = 0; i < 8; i++)
					vals[i] = 24'($urandom);
				default: vals = '{24'($urandom_range(1, 10000000)),
					24'($urandom_range(1, 20000)),
					24'($urandom_range(1, 10000000)),
					24'($urandom_range(1, 10000)),
					24'($urandom_range(1, 10000)),
					24'($urandom_range(0, 20000) - 10000),
					24'($urandom_range(0, 1)),
					24'($urandom_range(1, 65535))};
			endcase
			if (p == 2)
				vals[REG_COUNTMAX] = 24'd1023;
			write_all(vals);
			if (p == 1)
				hold_long = 1'b1;
			if (p == NUM_PHASES - 1)
				quiet = 1'b1;
			for (int n = 0; n < RAND_PER_PHASE; n++)
				send_sample(pick_count(), 1'b0, none);
		end

		drain();
		$display("%0d samples over %0d calibration sets, %0d results checked",
			samples_sent, NUM_PHASES + 1, readings_checked);
		$display("status ok %0d, zero count %0d, bad resistance %0d, saturated %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (mismatches == 0 && pending_readings.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
